// ===== sv/itrd_pkg.sv =====
// Shared types, constants and the digit-to-ASCII function for the
// integer to radix digits block. No dependencies.
package itrd_pkg;

	typedef logic [5:0] base_t;
	typedef logic [6:0] char_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_READ,
		BK_LOAD
	} back_state_t;

	// accepted radix range
	localparam base_t BASE_MIN = 6'd2;
	localparam base_t BASE_MAX = 6'd36;

	// digit coding
	localparam base_t DEC_LIMIT  = 6'd9;
	localparam char_t ASCII_ZERO = 7'h30;
	localparam char_t ASCII_A    = 7'h41;

	// most digits kept for one word, whatever the store depth
	localparam int RESULT_LIMIT = 32;

	// 0-9 map to '0'-'9', 10 and up to 'A'-'Z'
	function automatic char_t digit_to_ascii(base_t d);
		char_t c;
		if (d > DEC_LIMIT) begin
			c = {1'b0, d} + (ASCII_A - 7'd10);
		end else begin
			c = {1'b0, d} + ASCII_ZERO;
		end
		return c;
	endfunction

endpackage

// ===== sv/itrd_front.sv =====
// Front end: takes input words, forms the magnitude and clamps the radix.
// Depends on itrd_pkg.
module itrd_front import itrd_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	input  base_t                        base,
	output logic                         push,
	input  logic                         full,
	output logic [VALUE_BITS+5:0]        push_data
);

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	base_t                 base_c;

	// drop the sign; the most negative value wraps to 2^(VALUE_BITS-1)
	always_comb begin
		raw = $unsigned(value);
		if (raw[VALUE_BITS-1]) begin
			mag = ~raw + 1'b1;
		end else begin
			mag = raw;
		end
	end

	// radix clamp to 2..36
	always_comb begin
		if (base < BASE_MIN) begin
			base_c = BASE_MIN;
		end else if (base > BASE_MAX) begin
			base_c = BASE_MAX;
		end else begin
			base_c = base;
		end
	end

	assign in_ready  = !full;
	assign push      = in_valid && !full;
	assign push_data = {base_c, mag};

endmodule

// ===== sv/itrd_fifo.sv =====
// Two-entry queue between front and back ends.
// Depends on itrd_pkg only through the instantiating modules.
module itrd_fifo #(
	parameter int WIDTH = 38
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/itrd_back.sv =====
// Back end: shared restoring divider, digit store and output register.
// Depends on itrd_pkg.
module itrd_back import itrd_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  task_valid,
	output logic                  task_ready,
	input  logic [VALUE_BITS+5:0] task_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output char_t                 digit_char,
	output logic                  last
);

	localparam int LIM   = (MAX_DIGITS > RESULT_LIMIT) ? RESULT_LIMIT : MAX_DIGITS;
	localparam int IDX_W = $clog2(LIM);
	localparam int CNT_W = $clog2(LIM + 1);
	localparam int BC_W  = $clog2(VALUE_BITS);

	back_state_t           state_q, state_d;
	logic [VALUE_BITS-1:0] quo_q;
	base_t                 rem_q;
	base_t                 base_q;
	logic [BC_W-1:0]       bit_cnt_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      rd_idx_q;
	base_t                 rd_data_q;
	base_t                 digit_store_q [LIM];
	logic                  out_valid_q;
	char_t                 digit_q;
	logic                  last_q;

	logic [6:0]            shifted;
	logic [6:0]            diff;
	logic                  ge;
	base_t                 rem_next;
	logic [VALUE_BITS-1:0] quo_next;
	logic                  step_end;
	logic                  run_end;
	logic                  take;
	logic                  wr_en;
	logic                  load;

	// one quotient bit per cycle
	always_comb begin
		shifted  = {rem_q, quo_q[VALUE_BITS-1]};
		diff     = shifted - {1'b0, base_q};
		ge       = (shifted >= {1'b0, base_q});
		rem_next = ge ? diff[5:0] : shifted[5:0];
		quo_next = {quo_q[VALUE_BITS-2:0], ge};
		step_end = (bit_cnt_q == BC_W'(VALUE_BITS - 1));
		run_end  = (quo_next == '0) || (cnt_q == CNT_W'(LIM - 1));
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d = state_q;
		take    = 1'b0;
		wr_en   = 1'b0;
		load    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				take = task_valid;
				if (task_valid) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				wr_en = step_end;
				if (step_end && run_end) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				state_d = BK_LOAD;
			end
			BK_LOAD: begin
				load = !out_valid_q || out_ready;
				if (load) begin
					state_d = (rd_idx_q == '0) ? BK_IDLE : BK_READ;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign task_ready = (state_q == BK_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			bit_cnt_q   <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				bit_cnt_q <= '0;
				cnt_q     <= '0;
			end else if (state_q == BK_DIV) begin
				bit_cnt_q <= step_end ? '0 : bit_cnt_q + 1'b1;
				if (step_end) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// divider datapath and read pointer
	always_ff @(posedge clk) begin
		if (take) begin
			quo_q  <= task_data[VALUE_BITS-1:0];
			base_q <= task_data[VALUE_BITS+5:VALUE_BITS];
			rem_q  <= '0;
		end else if (state_q == BK_DIV) begin
			quo_q <= quo_next;
			rem_q <= step_end ? '0 : rem_next;
			if (step_end) begin
				rd_idx_q <= cnt_q[IDX_W-1:0];
			end
		end else if (load) begin
			rd_idx_q <= rd_idx_q - 1'b1;
		end
	end

	// digit store, least significant first
	always_ff @(posedge clk) begin
		if (wr_en) begin
			digit_store_q[cnt_q[IDX_W-1:0]] <= rem_next;
		end
		rd_data_q <= digit_store_q[rd_idx_q];
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load) begin
			digit_q <= digit_to_ascii(rd_data_q);
			last_q  <= (rd_idx_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_q;
	assign last       = last_q;

endmodule

// ===== sv/integer_to_radix_digits_top.sv =====
// Top level of the integer to radix digits block.
// Depends on itrd_pkg, itrd_front, itrd_fifo and itrd_back.
//
// Input channel (in_valid/in_ready): one word carries a signed value and a
// radix. The sign is dropped; radix values below 2 act as 2, above 36 as 36.
// Output channel (out_valid/out_ready): one word per digit, most significant
// first, as ASCII '0'-'9' then 'A'-'Z'; last marks the least significant digit.
// Zero gives the single digit '0'.
// Words pass through a two-entry queue to the back end, so the front keeps
// accepting while a conversion runs, until the queue is full.
// The back end owns one restoring divider producing one quotient bit per cycle
// while it divides. It divides out all digits of a word first, then emits each
// by a store read and then an output load, taking no new word until the last
// digit is loaded. Digits are capped at min(MAX_DIGITS, 32).
// When the receiver stalls, the output register holds its word and the back
// end waits; the queue absorbs up to two further words.
// Reset empties the queue and returns the back end to idle with no word shown.
module integer_to_radix_digits_top import itrd_pkg::*; #(
	parameter int MAX_DIGITS = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	input  base_t                        base,
	output logic                         out_valid,
	input  logic                         out_ready,
	output char_t                        digit_char,
	output logic                         last
);

	localparam int QW = VALUE_BITS + 6;

	logic          push;
	logic          full;
	logic [QW-1:0] push_data;
	logic          pop;
	logic          not_empty;
	logic          task_ready;
	logic [QW-1:0] pop_data;

	itrd_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.base     (base),
		.push     (push),
		.full     (full),
		.push_data(push_data)
	);

	itrd_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.pop_data (pop_data)
	);

	assign pop = not_empty && task_ready;

	itrd_back #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.task_valid(not_empty),
		.task_ready(task_ready),
		.task_data (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.digit_char(digit_char),
		.last      (last)
	);

endmodule

// ===== dv/integer_to_radix_digits_top_tb.sv =====
// Self-checking testbench for integer_to_radix_digits_top.
// Depends on itrd_pkg and the block's RTL; a digit predictor built in here
// checks every digit word against what each accepted value word should give.
module integer_to_radix_digits_top_tb;
	import itrd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIGITS = 32;
	localparam int VALUE_BITS = 32;
	localparam int DIGIT_CAP = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_PER_PHASE = 40;
	localparam int DRAIN_CYCLES = 1200;
	localparam int CYCLE_LIMIT = 1_200_000;

	typedef struct {
		logic signed [VALUE_BITS-1:0] value;
		base_t                        base;
	} conv_req_t;

	typedef struct {
		char_t ch;
		logic  last;
	} digit_t;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic signed [VALUE_BITS-1:0] value = '0;
	base_t                        base = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	char_t                        digit_char;
	logic                         last;

	conv_req_t req_queue[$];
	digit_t    digits_due[$];
	int        words_offered = 0;
	int        words_taken = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        errors = 0;
	int        cycles = 0;

	integer_to_radix_digits_top #(
		.MAX_DIGITS(MAX_DIGITS),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.base      (base),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.digit_char(digit_char),
		.last      (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Work out the digit words one value word should give, most significant first
	function automatic void queue_digits(logic [VALUE_BITS-1:0] raw, base_t b);
		logic [VALUE_BITS-1:0] mag;
		logic [VALUE_BITS-1:0] radix;
		base_t                 rems [DIGIT_CAP];
		int                    n;
		int                    k;
		digit_t                d;
		// out-of-range radix is clamped, sign is dropped
		radix = VALUE_BITS'((b < BASE_MIN) ? BASE_MIN : (b > BASE_MAX) ? BASE_MAX : b);
		mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
		n = 0;
		// zero still gives one digit
		do begin
			rems[n] = base_t'(mag % radix);
			mag = mag / radix;
			n++;
		end while (mag != 0 && n < DIGIT_CAP);
		for (k = n - 1; k >= 0; k--) begin
			if (rems[k] > DEC_LIMIT) begin
				d.ch = char_t'(rems[k]) - 7'd10 + ASCII_A;
			end else begin
				d.ch = char_t'(rems[k]) + ASCII_ZERO;
			end
			d.last = (k == 0);
			digits_due.push_back(d);
		end
	endfunction

	// Driver: new word or idle once the last one is taken; random receiver stalls
	always @(negedge clk) begin
		conv_req_t req;
		if (arst_n) begin
			if (!(in_valid && words_taken != words_offered)) begin
				if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req = req_queue.pop_front();
					value <= req.value;
					base <= req.base;
					in_valid <= 1'b1;
					words_offered++;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on each accepted value word, check each digit word
	always @(posedge clk) begin
		digit_t d;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				queue_digits(value, base);
				words_taken++;
			end
			if (out_valid && out_ready) begin
				if (digits_due.size() == 0) begin
					$display("%0t: digit word 0x%02h last %0b with none expected",
						$time, digit_char, last);
					errors++;
				end else begin
					d = digits_due.pop_front();
					if (digit_char !== d.ch) begin
						$display("%0t: digit_char expected 0x%02h, got 0x%02h",
							$time, d.ch, digit_char);
						errors++;
					end
					if (last !== d.last) begin
						$display("%0t: last expected %0b, got %0b", $time, d.last, last);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_word(logic signed [VALUE_BITS-1:0] v, base_t b);
		conv_req_t req;
		req.value = v;
		req.base = b;
		req_queue.push_back(req);
	endtask

	// Mix of full-range, small, negative and near-extreme values
	function automatic logic [VALUE_BITS-1:0] pick_value();
		logic [VALUE_BITS-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 99);
			3: v = -$urandom_range(1, 5000);
			4: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
				: 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: v = $urandom >> $urandom_range(0, 31);
		endcase
		return v;
	endfunction

	// Queue random words under one idling pattern, then let everything drain
	task automatic run_phase(int send_pct, int recv_pct, int count);
		int i;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (i = 0; i < count; i++) begin
			add_word(pick_value(), ($urandom_range(0, 9) == 0) ? base_t'($urandom_range(0, 63))
				: base_t'($urandom_range(2, 36)));
		end
		while (req_queue.size() != 0 || words_taken != words_offered || digits_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed: zero, extremes, letter digits, clamped radices
		add_word(0, 6'd10);
		add_word(0, 6'd2);
		add_word(1, 6'd2);
		add_word(-1, 6'd16);
		add_word(32'sh7FFF_FFFF, 6'd2);
		add_word(32'sh8000_0000, 6'd2);
		add_word(32'sh8000_0000, 6'd36);
		add_word(32'sh7FFF_FFFF, 6'd36);
		add_word(35, 6'd36);
		add_word(1295, 6'd36);
		add_word(10, 6'd11);
		add_word(9, 6'd10);
		add_word(-2147483647, 6'd10);
		add_word(255, 6'd0);
		add_word(255, 6'd1);
		add_word(1295, 6'd37);
		add_word(-1295, 6'd63);
		add_word(32'shDEAD_BEEF, 6'd16);
		add_word(100, 6'd32);
		add_word(0, 6'd63);

		run_phase(0, 0, RANDOM_PER_PHASE);
		run_phase(61, 0, RANDOM_PER_PHASE);
		run_phase(0, 61, RANDOM_PER_PHASE);
		run_phase(17, 17, RANDOM_PER_PHASE);

		// catch any stray digit words after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== integer_to_radix_digits_top.f =====
sv/itrd_pkg.sv
sv/itrd_front.sv
sv/itrd_fifo.sv
sv/itrd_back.sv
sv/integer_to_radix_digits_top.sv
dv/integer_to_radix_digits_top_tb.sv
